// ===== design/icmp_chk_pkg.sv =====
// Package with the shared types, constants and check codes of the ICMP echo reply checker.
`default_nettype none

package icmp_chk_pkg;

   localparam int MAX_FRAME = 2048;
   localparam int POS_W = 12;

   typedef logic [POS_W-1:0] pos_type;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [12:0] MIN_FRAME = 13'd42;
   localparam logic [15:0] SUM_ALL_ONES = 16'hFFFF;
   localparam logic [6:0] ETH_HEADER = 7'd14;
   localparam logic [6:0] ICMP_HEADER = 7'd8;
   localparam logic [3:0] MIN_IHL = 4'd5;
   localparam logic [7:0] PROTO_ICMP = 8'd1;
   localparam logic [7:0] ICMP_ECHO_REPLY = 8'd0;

   localparam pos_type POS_ETYPE_LO = pos_type'(13);
   localparam pos_type POS_IHL = pos_type'(14);
   localparam pos_type POS_LEN_HI = pos_type'(16);
   localparam pos_type POS_LEN_LO = pos_type'(17);
   localparam pos_type POS_PROTO = pos_type'(23);
   localparam pos_type POS_SRC_END = pos_type'(29);
   localparam pos_type POS_DST_END = pos_type'(33);
   localparam pos_type POS_ICMP_MIN = pos_type'(34);
   localparam pos_type POS_MAX = pos_type'(MAX_FRAME);

   localparam int CHK_W = 7;
   localparam int CHK_ETH_IHL = 0;
   localparam int CHK_PROTO = 1;
   localparam int CHK_SRC = 2;
   localparam int CHK_DST = 3;
   localparam int CHK_TYPE = 4;
   localparam int CHK_ID_SEQ = 5;
   localparam int CHK_SIZE = 6;
   localparam logic [CHK_W-1:0] ALL_CHECKS = '1;

   localparam logic [1:0] CSR_LOCAL_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_REMOTE_ADDRESS = 2'd1;
   localparam logic [1:0] CSR_EXPECTED_IDENT = 2'd2;
   localparam logic [1:0] CSR_EXPECTED_SEQUENCE = 2'd3;

   typedef struct packed {
      logic [31:0] local_address;
      logic [31:0] remote_address;
      logic [15:0] expected_ident;
      logic [15:0] expected_sequence;
   } cfg_type;

   typedef struct packed {
      logic       step;
      logic [7:0] frame_byte;
      logic       end_of_frame;
   } item_type;

   function automatic logic [15:0] ones_add(input logic [15:0] acc, input logic [15:0] word);
      logic [16:0] s;
      s = {1'b0, acc} + {1'b0, word};
      return s[15:0] + {15'd0, s[16]};
   endfunction

endpackage

`default_nettype wire

// ===== design/icmp_echo_reply_frame_checker.sv =====
// Top level of the ICMP echo reply checker with input register, result register and CSRs.
`default_nettype none

// Channel  Direction  Payload
// req      in         tdata[7:0] frame_byte, tlast end_of_frame
// rsp      out        tdata[0] is_matching_reply, tdata[7:1] zero
// csr      in         csr_index selects local, remote, ident, sequence
//
// Each byte is registered, then parsed by the core; one byte per cycle is sustained while the result is not stalled.
// The verdict becomes valid on rsp after the last byte has passed the input register and the result register.
// Reset clears all frame state, the CSRs and the valid flags; the checker then waits for a new frame.
// A stalled result holds the next last byte in the input register, and input waits behind it.

module icmp_echo_reply_frame_checker
   import icmp_chk_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // frame_byte
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [7:0]  rsp_tdata,   // is_matching_reply, then zero padding
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   cfg_type     cfg_ff, cfg_in;
   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_byte_ff;
   logic        s1_last_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_match_ff, rsp_match_in;
   logic        s1_adv;
   logic        accept;
   item_type    item;
   logic        match;

   always_comb begin
      s1_adv = !s1_last_ff || !rsp_valid_ff || rsp_tready;
      req_tready = !s1_valid_ff || s1_adv;
      accept = req_tvalid && req_tready;
      item.step = s1_valid_ff && s1_adv;
      item.frame_byte = s1_byte_ff;
      item.end_of_frame = s1_last_ff;

      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (item.step) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      rsp_match_in = rsp_match_ff;
      if (item.step && s1_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_match_in = match;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LOCAL_ADDRESS:     cfg_in.local_address = csr_data;
            CSR_REMOTE_ADDRESS:    cfg_in.remote_address = csr_data;
            CSR_EXPECTED_IDENT:    cfg_in.expected_ident = csr_data[15:0];
            CSR_EXPECTED_SEQUENCE: cfg_in.expected_sequence = csr_data[15:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   icmp_chk_core u_core (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .item              (item),
      .is_matching_reply (match)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_byte_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
      rsp_match_ff <= rsp_match_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {7'd0, rsp_match_ff};

endmodule

`default_nettype wire

// ===== design/icmp_chk_sum.sv =====
// One's complement checksum accumulator over 16-bit words.
`default_nettype none

module icmp_chk_sum
   import icmp_chk_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        add_en,
   input  wire logic        clear,
   input  wire logic [15:0] word,
   output logic      [15:0] sum_upd
);

   logic [15:0] sum_ff;
   logic [15:0] sum_in;

   always_comb begin
      sum_upd = add_en ? ones_add(sum_ff, word) : sum_ff;
      sum_in = clear ? 16'd0 : sum_upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= 16'd0;
      end else begin
         sum_ff <= sum_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/icmp_chk_core.sv =====
// Per-byte frame parser that tracks position, header fields, checks and checksums.
`default_nettype none

module icmp_chk_core
   import icmp_chk_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire item_type item,
   output logic          is_matching_reply
);

   pos_type           pos_ff, pos_in;
   logic [3:0]        hw_ff, hw_in;
   logic [15:0]       tl_ff, tl_in;
   logic [7:0]        pend_ff, pend_in;
   logic [31:0]       fs_ff, fs_in;
   logic [CHK_W-1:0]  chk_ff, chk_in;

   logic [7:0]        b;
   logic              odd;
   pos_type           pos_m1;
   logic [31:0]       fs_new;
   logic [3:0]        hw_cur;
   logic [15:0]       tl_cur;
   logic [5:0]        hdr_len;
   logic [6:0]        icmp_at;
   logic [16:0]       msg_end;
   logic              hdr_prev, hdr_cur, msg_prev, msg_cur;
   logic [CHK_W-1:0]  chk_upd;
   logic              hdr_add, msg_add;
   logic [15:0]       hdr_word, msg_word;
   logic [15:0]       hdr_sum, msg_sum;
   logic              clear;
   logic [12:0]       len;

   function automatic logic in_hdr(input pos_type q, input logic [6:0] at);
      return (q >= pos_type'(ETH_HEADER)) && (q < pos_type'(at));
   endfunction

   function automatic logic in_msg(input pos_type q, input logic [6:0] at,
                                   input logic [16:0] msg_lim);
      return (q >= pos_type'(at)) && ({5'd0, q} < msg_lim);
   endfunction

   always_comb begin
      b = item.frame_byte;
      odd = pos_ff[0];
      pos_m1 = pos_ff - pos_type'(1);
      fs_new = {fs_ff[23:0], b};
      hw_cur = (pos_ff == POS_IHL) ? b[3:0] : hw_ff;
      if (pos_ff == POS_LEN_HI) begin
         tl_cur = {b, 8'd0};
      end else if (pos_ff == POS_LEN_LO) begin
         tl_cur = {tl_ff[15:8], b};
      end else begin
         tl_cur = tl_ff;
      end
      hdr_len = {hw_cur, 2'b00};
      icmp_at = ETH_HEADER + {1'b0, hdr_len};
      msg_end = {10'd0, ETH_HEADER} + {1'b0, tl_cur};
      hdr_prev = in_hdr(pos_m1, icmp_at);
      hdr_cur = in_hdr(pos_ff, icmp_at);
      msg_prev = in_msg(pos_m1, icmp_at, msg_end);
      msg_cur = in_msg(pos_ff, icmp_at, msg_end);

      chk_upd = chk_ff;
      if (pos_ff >= POS_MAX) chk_upd[CHK_SIZE] = 1'b0;
      if (pos_ff == POS_ETYPE_LO && fs_new[15:0] != ETHERTYPE_IPV4) chk_upd[CHK_ETH_IHL] = 1'b0;
      if (pos_ff == POS_IHL && b[3:0] < MIN_IHL) chk_upd[CHK_ETH_IHL] = 1'b0;
      if (pos_ff == POS_PROTO && b != PROTO_ICMP) chk_upd[CHK_PROTO] = 1'b0;
      if (pos_ff == POS_SRC_END && fs_new != cfg.remote_address) chk_upd[CHK_SRC] = 1'b0;
      if (pos_ff == POS_DST_END && fs_new != cfg.local_address) chk_upd[CHK_DST] = 1'b0;
      if (pos_ff >= POS_ICMP_MIN) begin
         if (pos_ff == pos_type'(icmp_at) && b != ICMP_ECHO_REPLY) begin
            chk_upd[CHK_TYPE] = 1'b0;
         end
         if (pos_ff == pos_type'(icmp_at) + pos_type'(5)
             && fs_new[15:0] != cfg.expected_ident) begin
            chk_upd[CHK_ID_SEQ] = 1'b0;
         end
         if (pos_ff == pos_type'(icmp_at) + pos_type'(7)
             && fs_new[15:0] != cfg.expected_sequence) begin
            chk_upd[CHK_ID_SEQ] = 1'b0;
         end
      end

      if (odd) begin
         hdr_add = item.step && hdr_prev;
         msg_add = item.step && msg_prev;
         hdr_word = {pend_ff, b};
         msg_word = msg_cur ? {pend_ff, b} : {pend_ff, 8'd0};
      end else begin
         hdr_add = item.step && item.end_of_frame && hdr_cur;
         msg_add = item.step && item.end_of_frame && msg_cur;
         hdr_word = {b, 8'd0};
         msg_word = {b, 8'd0};
      end
      clear = item.step && item.end_of_frame;

      len = {1'b0, pos_ff} + 13'd1;
   end

   icmp_chk_sum u_hdr_sum (
      .clock   (clock),
      .reset   (reset),
      .add_en  (hdr_add),
      .clear   (clear),
      .word    (hdr_word),
      .sum_upd (hdr_sum)
   );

   icmp_chk_sum u_msg_sum (
      .clock   (clock),
      .reset   (reset),
      .add_en  (msg_add),
      .clear   (clear),
      .word    (msg_word),
      .sum_upd (msg_sum)
   );

   always_comb begin
      is_matching_reply = (chk_upd == ALL_CHECKS)
                          && (len >= MIN_FRAME)
                          && (len >= {6'd0, icmp_at} + {6'd0, ICMP_HEADER})
                          && (tl_cur >= {10'd0, hdr_len})
                          && (hdr_sum == SUM_ALL_ONES)
                          && (msg_sum == SUM_ALL_ONES);

      pos_in = pos_ff;
      hw_in = hw_ff;
      tl_in = tl_ff;
      pend_in = pend_ff;
      fs_in = fs_ff;
      chk_in = chk_ff;
      if (item.step) begin
         if (item.end_of_frame) begin
            pos_in = '0;
            hw_in = '0;
            tl_in = '0;
            pend_in = '0;
            fs_in = '0;
            chk_in = ALL_CHECKS;
         end else begin
            if (pos_ff < POS_MAX) pos_in = pos_ff + pos_type'(1);
            hw_in = hw_cur;
            tl_in = tl_cur;
            if (!odd) pend_in = b;
            fs_in = fs_new;
            chk_in = chk_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         hw_ff <= '0;
         tl_ff <= '0;
         pend_ff <= '0;
         fs_ff <= '0;
         chk_ff <= ALL_CHECKS;
      end else begin
         pos_ff <= pos_in;
         hw_ff <= hw_in;
         tl_ff <= tl_in;
         pend_ff <= pend_in;
         fs_ff <= fs_in;
         chk_ff <= chk_in;
      end
   end

endmodule

`default_nettype wire
